[rtl/assert_macros.svh]
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define VPDP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define VPDP_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define VPDP_ASSERT(label, clk, rst_n, prop)

`define VPDP_NEVER(label, clk, rst_n, expr)

`endif

`endif

[rtl/vpdp_pkg.sv]
package vpdp_pkg;

  localparam int unsigned MAX_REF_DIFFS = 3;
  localparam logic [10:0] BYTE_COUNT_MAX = 11'd2047;

  localparam logic [3:0] KIND_FLAGS     = 4'd0;
  localparam logic [3:0] KIND_PICID     = 4'd1;
  localparam logic [3:0] KIND_LAYER     = 4'd2;
  localparam logic [3:0] KIND_TL0IDX    = 4'd3;
  localparam logic [3:0] KIND_REFDIFF   = 4'd4;
  localparam logic [3:0] KIND_SSHDR     = 4'd5;
  localparam logic [3:0] KIND_RES       = 4'd6;
  localparam logic [3:0] KIND_GRP_COUNT = 4'd7;
  localparam logic [3:0] KIND_GRP_HDR   = 4'd8;
  localparam logic [3:0] KIND_GRP_DIFF  = 4'd9;
  localparam logic [3:0] KIND_TRUNC     = 4'd10;

  localparam int unsigned F_I_BIT = 7;
  localparam int unsigned F_P_BIT = 6;
  localparam int unsigned F_L_BIT = 5;
  localparam int unsigned F_F_BIT = 4;
  localparam int unsigned F_V_BIT = 1;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_PID0    = 4'd1,
    PH_PID1    = 4'd2,
    PH_LAYER   = 4'd3,
    PH_TL0     = 4'd4,
    PH_REFDIFF = 4'd5,
    PH_SSHDR   = 4'd6,
    PH_RES     = 4'd7,
    PH_NG      = 4'd8,
    PH_GHDR    = 4'd9,
    PH_GDIFF   = 4'd10,
    PH_DONE    = 4'd11
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [7:0]  element_index;
    logic [10:0] header_length;
    logic        is_last;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic fire;
  } step_ctl_t;

endpackage

[rtl/vpdp_in_reg.sv]
module vpdp_in_reg
  import vpdp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     valid,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

[rtl/vpdp_step.sv]
`include "assert_macros.svh"

module vpdp_step
  import vpdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  step_ctl_t ctl,
  input  in_item_t  item,
  output logic      rec_valid,
  output out_item_t rec
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  flag_bits_r, flag_bits_nxt;
  logic [1:0]  bie_r, bie_nxt;
  logic [23:0] partial_r, partial_nxt;
  logic [7:0]  list_index_r, list_index_nxt;
  logic [7:0]  list_count_r, list_count_nxt;
  logic [2:0]  spatial_count_r, spatial_count_nxt;
  logic [1:0]  ss_flags_r, ss_flags_nxt;
  logic [1:0]  gdl_r, gdl_nxt;
  logic [10:0] byte_count_r, byte_count_nxt;

  function automatic phase_t after_ref(input logic [7:0] f);
    return f[F_V_BIT] ? PH_SSHDR : PH_DONE;
  endfunction

  function automatic phase_t after_layer(input logic [7:0] f);
    return (f[F_P_BIT] && f[F_F_BIT]) ? PH_REFDIFF : after_ref(f);
  endfunction

  function automatic phase_t after_pid(input logic [7:0] f);
    return f[F_L_BIT] ? PH_LAYER : after_layer(f);
  endfunction

  logic [7:0] d;
  logic       emit;
  logic [3:0] kind;
  logic [15:0] va, vb;
  logic [7:0] vidx;
  logic [7:0] li_inc;
  logic [1:0] gdl_dec;
  logic       active;

  assign d       = item.data_byte;
  assign li_inc  = list_index_r + 8'd1;
  assign gdl_dec = gdl_r - 2'd1;
  assign active  = (phase_r != PH_IDLE) && (phase_r != PH_DONE);

  always_comb begin
    phase_nxt         = phase_r;
    flag_bits_nxt     = flag_bits_r;
    bie_nxt           = bie_r;
    partial_nxt       = partial_r;
    list_index_nxt    = list_index_r;
    list_count_nxt    = list_count_r;
    spatial_count_nxt = spatial_count_r;
    ss_flags_nxt      = ss_flags_r;
    gdl_nxt           = gdl_r;
    byte_count_nxt    = byte_count_r;
    emit = 1'b0;
    kind = KIND_FLAGS;
    va   = '0;
    vb   = '0;
    vidx = '0;

    if (item.first_byte) begin
      flag_bits_nxt     = d;
      bie_nxt           = '0;
      partial_nxt       = '0;
      list_index_nxt    = '0;
      list_count_nxt    = '0;
      spatial_count_nxt = '0;
      ss_flags_nxt      = '0;
      gdl_nxt           = '0;
      byte_count_nxt    = 11'd1;
      emit = 1'b1;
      kind = KIND_FLAGS;
      va   = {8'd0, d};
      phase_nxt = d[F_I_BIT] ? PH_PID0 : after_pid(d);
    end else if (active) begin
      if (byte_count_r < BYTE_COUNT_MAX) begin
        byte_count_nxt = byte_count_r + 11'd1;
      end
      case (phase_r)
        PH_PID0: begin
          if (d[7]) begin
            partial_nxt = {17'd0, d[6:0]};
            phase_nxt   = PH_PID1;
          end else begin
            emit = 1'b1;
            kind = KIND_PICID;
            va   = {9'd0, d[6:0]};
            phase_nxt = after_pid(flag_bits_r);
            list_index_nxt = '0;
          end
        end
        PH_PID1: begin
          emit = 1'b1;
          kind = KIND_PICID;
          va   = {1'b0, partial_r[6:0], d};
          vb   = 16'd1;
          phase_nxt = after_pid(flag_bits_r);
          list_index_nxt = '0;
        end
        PH_LAYER: begin
          emit = 1'b1;
          kind = KIND_LAYER;
          va   = {13'd0, d[7:5]};
          vb   = {11'd0, d[3:1], d[4], d[0]};
          if (flag_bits_r[F_F_BIT]) begin
            phase_nxt = after_layer(flag_bits_r);
            list_index_nxt = '0;
          end else begin
            phase_nxt = PH_TL0;
          end
        end
        PH_TL0: begin
          emit = 1'b1;
          kind = KIND_TL0IDX;
          va   = {8'd0, d};
          phase_nxt = after_layer(flag_bits_r);
          list_index_nxt = '0;
        end
        PH_REFDIFF: begin
          emit = 1'b1;
          kind = KIND_REFDIFF;
          va   = {9'd0, d[7:1]};
          vidx = list_index_r;
          list_index_nxt = li_inc;
          if (!(d[0] && (li_inc < 8'(MAX_REF_DIFFS)))) begin
            phase_nxt = after_ref(flag_bits_r);
          end
        end
        PH_SSHDR: begin
          emit = 1'b1;
          kind = KIND_SSHDR;
          va   = {13'd0, d[7:5]};
          vb   = {14'd0, d[4:3]};
          spatial_count_nxt = d[7:5];
          ss_flags_nxt      = d[4:3];
          if (d[4]) begin
            list_index_nxt = '0;
            bie_nxt        = '0;
            partial_nxt    = '0;
            phase_nxt      = PH_RES;
          end else begin
            phase_nxt = d[3] ? PH_NG : PH_DONE;
          end
        end
        PH_RES: begin
          if (bie_r != 2'd3) begin
            partial_nxt = {partial_r[15:0], d};
            bie_nxt     = bie_r + 2'd1;
          end else begin
            emit = 1'b1;
            kind = KIND_RES;
            va   = partial_r[23:8];
            vb   = {partial_r[7:0], d};
            vidx = list_index_r;
            bie_nxt     = '0;
            partial_nxt = '0;
            if (list_index_r < {5'd0, spatial_count_r}) begin
              list_index_nxt = li_inc;
            end else begin
              phase_nxt = ss_flags_r[0] ? PH_NG : PH_DONE;
            end
          end
        end
        PH_NG: begin
          emit = 1'b1;
          kind = KIND_GRP_COUNT;
          va   = {8'd0, d};
          list_count_nxt = d;
          list_index_nxt = '0;
          phase_nxt = (d != 8'd0) ? PH_GHDR : PH_DONE;
        end
        PH_GHDR: begin
          emit = 1'b1;
          kind = KIND_GRP_HDR;
          va   = {13'd0, d[7:5]};
          vb   = {13'd0, d[4], d[3:2]};
          vidx = list_index_r;
          if (d[3:2] != 2'd0) begin
            gdl_nxt     = d[3:2];
            partial_nxt = {22'd0, d[3:2]};
            phase_nxt   = PH_GDIFF;
          end else begin
            list_index_nxt = li_inc;
            phase_nxt = ((li_inc != 8'd0) && (li_inc < list_count_r)) ? PH_GHDR : PH_DONE;
          end
        end
        PH_GDIFF: begin
          emit = 1'b1;
          kind = KIND_GRP_DIFF;
          va   = {8'd0, d};
          vidx = {6'd0, partial_r[1:0] - gdl_r};
          gdl_nxt = gdl_dec;
          if (gdl_dec == 2'd0) begin
            list_index_nxt = li_inc;
            phase_nxt = ((li_inc != 8'd0) && (li_inc < list_count_r)) ? PH_GHDR : PH_DONE;
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase
    end

    if ((item.first_byte || active) && item.last_byte && (phase_nxt != PH_DONE)) begin
      phase_nxt = PH_DONE;
      emit = 1'b1;
      kind = KIND_TRUNC;
      va   = '0;
      vb   = '0;
      vidx = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      flag_bits_r     <= '0;
      bie_r           <= '0;
      partial_r       <= '0;
      list_index_r    <= '0;
      list_count_r    <= '0;
      spatial_count_r <= '0;
      ss_flags_r      <= '0;
      gdl_r           <= '0;
      byte_count_r    <= '0;
    end else if (ctl.fire) begin
      phase_r         <= phase_nxt;
      flag_bits_r     <= flag_bits_nxt;
      bie_r           <= bie_nxt;
      partial_r       <= partial_nxt;
      list_index_r    <= list_index_nxt;
      list_count_r    <= list_count_nxt;
      spatial_count_r <= spatial_count_nxt;
      ss_flags_r      <= ss_flags_nxt;
      gdl_r           <= gdl_nxt;
      byte_count_r    <= byte_count_nxt;
    end
  end

  assign rec_valid = ctl.valid && emit;
  assign rec.record_kind   = kind;
  assign rec.value_a       = va;
  assign rec.value_b       = vb;
  assign rec.element_index = vidx;
  assign rec.header_length = byte_count_nxt;
  assign rec.is_last       = (phase_nxt == PH_DONE);

  `VPDP_ASSERT(a_last_ends, clk, rst_n, (ctl.fire && rec_valid && rec.is_last) |=> (phase_r == PH_DONE))
  `VPDP_NEVER(a_trunc_last, clk, rst_n, ctl.fire && rec_valid && (rec.record_kind == KIND_TRUNC) && !rec.is_last)
  `VPDP_NEVER(a_len_nonzero, clk, rst_n, ctl.fire && rec_valid && (rec.header_length == 11'd0))
  `VPDP_ASSERT(a_idle_quiet, clk, rst_n, (ctl.fire && (phase_r == PH_IDLE) && !item.first_byte) |-> !rec_valid)

endmodule

[rtl/vpdp_out_buf.sv]
module vpdp_out_buf
  import vpdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_item_t push_item,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t   slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign can_push  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/vp9_payload_descriptor_parser_core.sv]
// VP9 RTP payload descriptor parser. Packet bytes enter one per cycle on the in_ channel
// when in_ready is high; first_byte restarts parsing on the flag byte and last_byte
// marks the end of the buffer. Each completed element (flags, picture id, layer,
// tl0picidx, reference diffs, scalability header, resolutions, group count, group headers
// and diffs) leaves as one tagged record on the out_ channel; the record with is_last set
// ends the descriptor, carries its length in header_length, or reports a truncated buffer.
// Throughput is one byte per cycle while the buffer has room: each byte moves from the
// input register through the state update into a two-entry result buffer, which drives
// out_valid; back-pressure only stalls input once that buffer is full.
module vp9_payload_descriptor_parser_core
  import vpdp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      stage_valid;
  in_item_t  stage_item;
  logic      can_push;
  step_ctl_t ctl;
  logic      rec_valid;
  out_item_t rec;

  assign ctl.valid = stage_valid;
  assign ctl.fire  = stage_valid && can_push;

  vpdp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (ctl.fire),
    .valid    (stage_valid),
    .item     (stage_item)
  );

  vpdp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .item      (stage_item),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  vpdp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ctl.fire && rec_valid),
    .push_item (rec),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
